// ===== rtl/core/dedq_pkg.sv =====
// package for the double-ended queue: opcodes, widths, fsm states and control structs
`timescale 1ns / 1ps

package dedq_pkg;

    // default sizes handed to the top level parameters
    localparam int DEFAULT_CAPACITY   = 16;
    localparam int DEFAULT_VALUE_BITS = 32;

    // port field widths
    localparam int FUNC_W     = 3;
    localparam int IN_DATA_W  = 32;
    localparam int POP_W      = 32;
    localparam int COUNT_W    = 5;
    localparam int OUT_DATA_W = 40;

    // operation codes carried in the input tuser
    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4,
        OP_SIZE       = 3'd5
    } t_op;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic latch;
        logic exec;
        logic emit;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/core/dedq_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
`timescale 1ns / 1ps

module dedq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/dedq_ctrl.sv =====
// controller fsm: accept a word, execute it, hand the result to the output register
`timescale 1ns / 1ps

module dedq_ctrl
    import dedq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.latch = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/dedq_dp.sv =====
// datapath: ring pointers, element count, ring ram and the output register
`timescale 1ns / 1ps

module dedq_dp
    import dedq_pkg::*;
#(
    parameter int CAPACITY   = DEFAULT_CAPACITY,
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [IN_DATA_W-1:0]  i_push_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    localparam int PW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    // latched word
    logic [FUNC_W-1:0]     r_func;
    logic [VALUE_BITS-1:0] r_value;

    // queue state
    logic [PW-1:0] r_front;
    logic [PW-1:0] n_front;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    // result flags
    logic r_pop_ok;
    logic n_pop_ok;
    logic r_empty;
    logic n_empty;
    logic r_ovf;
    logic n_ovf;

    // output register
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // ram ports
    logic                  w_we;
    logic [PW-1:0]         w_waddr;
    logic                  w_re;
    logic [PW-1:0]         w_raddr;
    logic [VALUE_BITS-1:0] w_rdata;

    // ring index math
    logic [SW-1:0]   w_sum_back;
    logic [SW-1:0]   w_sum_last;
    logic [PW-1:0]   w_back_idx;
    logic [PW-1:0]   w_last_idx;
    logic [PW-1:0]   w_next_front;
    logic [PW-1:0]   w_prev_front;
    logic            w_full;
    logic            w_is_empty;
    logic            w_is_pop;
    logic [POP_W-1:0] w_pop_value;

    // input value sign-extended or cut to the stored width
    logic signed [IN_DATA_W-1:0] w_in_signed;
    assign w_in_signed = signed'(i_push_value);

    // latch the accepted word
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func  <= i_func;
            r_value <= VALUE_BITS'(w_in_signed);
        end
    end

    // ring offsets from the front pointer, one wrap at most
    assign w_sum_back   = SW'(r_front) + SW'(r_count);
    assign w_sum_last   = w_sum_back - SW'(1);
    assign w_back_idx   = (w_sum_back >= SW'(CAPACITY)) ?
                          PW'(w_sum_back - SW'(CAPACITY)) : PW'(w_sum_back);
    assign w_last_idx   = (w_sum_last >= SW'(CAPACITY)) ?
                          PW'(w_sum_last - SW'(CAPACITY)) : PW'(w_sum_last);
    assign w_next_front = (r_front == PW'(CAPACITY - 1)) ? '0 : r_front + PW'(1);
    assign w_prev_front = (r_front == '0) ? PW'(CAPACITY - 1) : r_front - PW'(1);
    assign w_full       = (r_count == CW'(CAPACITY));
    assign w_is_empty   = (r_count == '0);
    assign w_is_pop     = (r_func == OP_POP_FRONT) || (r_func == OP_POP_BACK);

    // operation decode
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_pop_ok = 1'b0;
        n_empty  = 1'b0;
        n_ovf    = 1'b0;
        w_we     = 1'b0;
        w_waddr  = w_back_idx;
        w_re     = 1'b0;
        w_raddr  = r_front;
        case (r_func)
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_front = w_prev_front;
                    n_count = r_count + CW'(1);
                    w_we    = i_cmd.exec;
                    w_waddr = w_prev_front;
                end
            end
            OP_PUSH_BACK: begin
                if (w_full) begin
                    n_ovf = 1'b1;
                end else begin
                    n_count = r_count + CW'(1);
                    w_we    = i_cmd.exec;
                    w_waddr = w_back_idx;
                end
            end
            OP_POP_FRONT: begin
                if (w_is_empty) begin
                    n_empty = 1'b1;
                end else begin
                    n_pop_ok = 1'b1;
                    n_front  = w_next_front;
                    n_count  = r_count - CW'(1);
                    w_re     = i_cmd.exec;
                    w_raddr  = r_front;
                end
            end
            OP_POP_BACK: begin
                if (w_is_empty) begin
                    n_empty = 1'b1;
                end else begin
                    n_pop_ok = 1'b1;
                    n_count  = r_count - CW'(1);
                    w_re     = i_cmd.exec;
                    w_raddr  = w_last_idx;
                end
            end
            OP_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
                // size query and unused codes leave the state alone
                n_front = r_front;
            end
        endcase
    end

    // queue state update on execute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // result flags
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_pop_ok <= n_pop_ok;
            r_empty  <= n_empty;
            r_ovf    <= n_ovf;
        end
    end

    // ring storage
    dedq_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // popped value sign-extended or cut to 32 bits, all ones otherwise
    assign w_pop_value = r_pop_ok ? POP_W'(signed'(w_rdata)) : '1;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {1'b0, COUNT_W'(r_count), r_ovf, r_empty, w_pop_value};
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // checks on the queue state
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front <= PW'(CAPACITY - 1))
        else $error("front pointer out of ring");

    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && w_is_pop && !w_is_empty |=> r_count == $past(r_count) - CW'(1))
        else $error("successful pop did not decrement count");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec && (r_func == OP_CLEAR) |=> (r_count == '0) && (r_front == '0))
        else $error("clear left state behind");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> !(r_empty && r_ovf) && !(r_pop_ok && r_empty))
        else $error("conflicting result flags");

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// top level of the bounded double-ended queue
//
//  channel  | dir | tdata                    | tuser      | tlast
//  ---------+-----+--------------------------+------------+------
//  s_axis   | in  | push_value[31:0]         | func[2:0]  | none
//  m_axis   | out | pop_value, was_empty,    | none       | none
//           |     | overflow, element_count  |            |
//
// each word passes through accept, execute (one ring ram access) and emit
// into the output register; a pop's value comes from the ram's registered read
// a result waiting in the output register does not block the next accept;
// the emit step waits only while the output register is full and stalled
// synchronous active-low reset clears pointer, count and output valid;
// the ring contents are not cleared and need no clearing pass
`timescale 1ns / 1ps

module double_ended_queue
    import dedq_pkg::*;
#(
    parameter int CAPACITY   = DEFAULT_CAPACITY,
    parameter int VALUE_BITS = DEFAULT_VALUE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // push_value[31:0]
    input  logic [FUNC_W-1:0]     s_axis_tuser,  // func[2:0]
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // pop_value[31:0], was_empty[32],
                                                 // overflow[33], element_count[38:34]
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencing
    dedq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // queue storage and result
    dedq_dp #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_func       (s_axis_tuser),
        .i_push_value (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata)
    );

endmodule
